/* rtl/note_priority_tracker_assert.svh */
// ----------------------------------------------------------------------------
// note priority tracker assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NOTE_PRIORITY_TRACKER_ASSERT_SVH
`define NOTE_PRIORITY_TRACKER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define NPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define NPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/nptk_pkg.sv */
// ----------------------------------------------------------------------------
// nptk_pkg
// shared types and constants of the note priority tracker
// ----------------------------------------------------------------------------
package nptk_pkg;

  localparam int NOTE_W        = 6;
  localparam int CUR_W         = 7;
  localparam int SOLO_KEY_BITS = 18;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;

  localparam logic [1:0] ACT_SCAN      = 2'd0;
  localparam logic [1:0] ACT_KILL      = 2'd1;
  localparam logic [1:0] ACT_NO_ATTACK = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_HELD     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_STILL    = 3'd4
  } note_state_t;

  typedef enum logic [1:0] {
    OP_SCAN,
    OP_KILL,
    OP_NO_ATTACK,
    OP_NONE
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CHORD,
    PH_SOLO_KEYS,
    PH_SOLO_SCAN,
    PH_SOLO_OCT,
    PH_SOLO_RESOLVE,
    PH_KILL,
    PH_NO_ATTACK,
    PH_HANDOFF
  } phase_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cur_note;
    note_state_t       cur_state;
    logic [NOTE_W-1:0] prior_note;
    note_state_t       prev_state;
    logic              any_down;
    logic              any_pressed;
    logic              legato;
  } summary_t;

endpackage

/* rtl/nptk_front.sv */
// ----------------------------------------------------------------------------
// nptk_front
// request intake: decodes the action and queues requests for the executor
// ----------------------------------------------------------------------------
module nptk_front #(
  parameter int NUM_NOTES = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           action,
  input  logic [NUM_NOTES-1:0] keys_down,
  input  logic                 octave_changed,
  output logic                 q_valid,
  input  logic                 q_pop,
  output nptk_pkg::op_t        q_op,
  output logic [NUM_NOTES-1:0] q_keys,
  output logic                 q_octave
);

  nptk_pkg::op_t        op_mem     [nptk_pkg::QUEUE_DEPTH];
  logic [NUM_NOTES-1:0] keys_mem   [nptk_pkg::QUEUE_DEPTH];
  logic                 octave_mem [nptk_pkg::QUEUE_DEPTH];

  logic [nptk_pkg::QPTR_W-1:0] wr_ptr;
  logic [nptk_pkg::QPTR_W-1:0] rd_ptr;
  logic [nptk_pkg::QPTR_W:0]   count;
  nptk_pkg::op_t               op_dec;
  logic                        do_push;
  logic                        do_pop;

  always_comb begin
    case (action)
      nptk_pkg::ACT_SCAN:      op_dec = nptk_pkg::OP_SCAN;
      nptk_pkg::ACT_KILL:      op_dec = nptk_pkg::OP_KILL;
      nptk_pkg::ACT_NO_ATTACK: op_dec = nptk_pkg::OP_NO_ATTACK;
      default:                 op_dec = nptk_pkg::OP_NONE;
    endcase
  end

  assign full    = (count == (nptk_pkg::QPTR_W + 1)'(nptk_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  assign q_op     = op_mem[rd_ptr];
  assign q_keys   = keys_mem[rd_ptr];
  assign q_octave = octave_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      op_mem[wr_ptr]     <= op_dec;
      keys_mem[wr_ptr]   <= keys_down;
      octave_mem[wr_ptr] <= octave_changed;
    end
  end

endmodule

/* rtl/nptk_exec.sv */
// ----------------------------------------------------------------------------
// nptk_exec
// note state row and the sequencer that applies one request over a few steps
// ----------------------------------------------------------------------------
module nptk_exec #(
  parameter int NUM_NOTES = 33
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  nptk_pkg::op_t         q_op,
  input  logic [NUM_NOTES-1:0]  q_keys,
  input  logic                  q_octave,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output nptk_pkg::note_state_t snap_states [NUM_NOTES],
  output nptk_pkg::summary_t    snap_sum
);

  localparam logic [NUM_NOTES-1:0] SOLO_MASK =
    NUM_NOTES'((64'd1 << nptk_pkg::SOLO_KEY_BITS) - 64'd1);
  localparam logic [NUM_NOTES-1:0] ONE = NUM_NOTES'(1);

  function automatic logic [nptk_pkg::NOTE_W-1:0] lowest_set(
    input logic [NUM_NOTES-1:0] v
  );
    logic [nptk_pkg::NOTE_W-1:0] r;
    r = '0;
    for (int i = NUM_NOTES - 1; i >= 0; i--) begin
      if (v[i]) r = nptk_pkg::NOTE_W'(i);
    end
    return r;
  endfunction

  function automatic logic [nptk_pkg::NOTE_W-1:0] highest_set(
    input logic [NUM_NOTES-1:0] v
  );
    logic [nptk_pkg::NOTE_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_NOTES; i++) begin
      if (v[i]) r = nptk_pkg::NOTE_W'(i);
    end
    return r;
  endfunction

  nptk_pkg::phase_t      phase;
  nptk_pkg::phase_t      phase_next;
  nptk_pkg::note_state_t states      [NUM_NOTES];
  nptk_pkg::note_state_t states_next [NUM_NOTES];

  logic                        poly_on;
  logic [NUM_NOTES-1:0]        keys_now;
  logic [NUM_NOTES-1:0]        keys_before;
  logic [nptk_pkg::NOTE_W-1:0] last_note;
  nptk_pkg::note_state_t       last_note_state;

  logic [NUM_NOTES-1:0]        keys_r;
  logic                        octave_r;
  logic                        pressed_valid;
  logic [nptk_pkg::NOTE_W-1:0] pressed_idx;
  logic                        held_valid;
  logic [nptk_pkg::NOTE_W-1:0] held_idx;
  logic                        released_any;

  logic [NUM_NOTES-1:0]        ph_vec;
  logic [NUM_NOTES-1:0]        p_vec;
  logic [NUM_NOTES-1:0]        cur_oh;
  logic                        cur_valid;
  logic [nptk_pkg::NOTE_W-1:0] cur_idx;
  nptk_pkg::note_state_t       cur_state;
  nptk_pkg::note_state_t       last_sel_state;
  nptk_pkg::note_state_t       cs;

  logic [NUM_NOTES-1:0]        new_vec;
  logic [NUM_NOTES-1:0]        new_oh;
  logic [NUM_NOTES-1:0]        below;
  logic [NUM_NOTES-1:0]        hold_vec;
  logic [NUM_NOTES-1:0]        rel_vec;

  logic                        res_apply;
  logic                        tgt_valid;
  logic [nptk_pkg::NOTE_W-1:0] tgt_idx;
  nptk_pkg::note_state_t       tgt_state;
  logic                        mode_flip;

  // per-note flags of the current state row
  always_comb begin
    for (int i = 0; i < NUM_NOTES; i++) begin
      p_vec[i]  = (states[i] == nptk_pkg::ST_PRESSED);
      ph_vec[i] = (states[i] == nptk_pkg::ST_PRESSED) || (states[i] == nptk_pkg::ST_HELD);
    end
  end

  // current note: lowest pressed or held
  assign cur_oh    = ph_vec & (~ph_vec + ONE);
  assign cur_valid = |ph_vec;
  assign cur_idx   = lowest_set(ph_vec);
  assign cur_state = (|(p_vec & cur_oh)) ? nptk_pkg::ST_PRESSED : nptk_pkg::ST_HELD;

  always_comb begin
    last_sel_state = nptk_pkg::ST_IDLE;
    for (int i = 0; i < NUM_NOTES; i++) begin
      if (nptk_pkg::NOTE_W'(i) == last_note) last_sel_state = states[i];
    end
  end

  assign cs = cur_valid ? cur_state : last_sel_state;

  // solo scan: only notes below the first new press are touched (all without one)
  assign new_vec  = ~keys_before & keys_now;
  assign new_oh   = new_vec & (~new_vec + ONE);
  assign below    = new_oh - ONE;
  assign hold_vec = keys_before & keys_now & below;
  assign rel_vec  = keys_before & ~keys_now & below;

  // solo resolve: which note keeps the voice
  always_comb begin
    res_apply = 1'b1;
    tgt_valid = 1'b1;
    tgt_idx   = pressed_idx;
    tgt_state = nptk_pkg::ST_PRESSED;
    if (pressed_valid) begin
      tgt_idx   = pressed_idx;
    end else if (held_valid && !released_any) begin
      tgt_valid = cur_valid;
      tgt_idx   = cur_idx;
      tgt_state = nptk_pkg::ST_HELD;
    end else if (held_valid) begin
      tgt_idx   = held_idx;
      tgt_state = (held_idx == last_note) ? nptk_pkg::ST_HELD : nptk_pkg::ST_PRESSED;
    end else begin
      res_apply = 1'b0;
    end
  end

  assign mode_flip = cfg_we && (cfg_wdata != poly_on);

  // next value of every note cell
  always_comb begin
    for (int i = 0; i < NUM_NOTES; i++) begin
      states_next[i] = states[i];
      case (phase)
        nptk_pkg::PH_CHORD: begin
          if (states[i] == nptk_pkg::ST_RELEASED) begin
            states_next[i] = nptk_pkg::ST_STILL;
          end else if (keys_now[i] && keys_r[i]) begin
            states_next[i] = nptk_pkg::ST_HELD;
          end else if (!keys_now[i] && keys_r[i]) begin
            states_next[i] = nptk_pkg::ST_PRESSED;
          end else if (keys_now[i] && !keys_r[i]) begin
            states_next[i] = nptk_pkg::ST_RELEASED;
          end
        end
        nptk_pkg::PH_SOLO_SCAN: begin
          if (rel_vec[i]) begin
            states_next[i] = nptk_pkg::ST_RELEASED;
          end else if (below[i] && !keys_before[i] && !keys_now[i]) begin
            states_next[i] = nptk_pkg::ST_STILL;
          end
        end
        nptk_pkg::PH_SOLO_RESOLVE: begin
          if (res_apply) begin
            if (tgt_valid && (nptk_pkg::NOTE_W'(i) == tgt_idx)) begin
              states_next[i] = tgt_state;
            end else if (states[i] != nptk_pkg::ST_RELEASED) begin
              states_next[i] = nptk_pkg::ST_IDLE;
            end
          end
        end
        nptk_pkg::PH_KILL: begin
          states_next[i] = nptk_pkg::ST_IDLE;
        end
        nptk_pkg::PH_NO_ATTACK: begin
          if (cur_oh[i] && p_vec[i]) states_next[i] = nptk_pkg::ST_HELD;
        end
        default: begin
        end
      endcase
      if (mode_flip) states_next[i] = nptk_pkg::ST_IDLE;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nptk_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    q_pop      = 1'b0;
    snap_valid = 1'b0;
    case (phase)
      nptk_pkg::PH_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op)
            nptk_pkg::OP_SCAN:
              phase_next = poly_on ? nptk_pkg::PH_CHORD : nptk_pkg::PH_SOLO_KEYS;
            nptk_pkg::OP_KILL:      phase_next = nptk_pkg::PH_KILL;
            nptk_pkg::OP_NO_ATTACK: phase_next = nptk_pkg::PH_NO_ATTACK;
            default:                phase_next = nptk_pkg::PH_HANDOFF;
          endcase
        end
      end
      nptk_pkg::PH_CHORD:        phase_next = nptk_pkg::PH_HANDOFF;
      nptk_pkg::PH_SOLO_KEYS:    phase_next = nptk_pkg::PH_SOLO_SCAN;
      nptk_pkg::PH_SOLO_SCAN:    phase_next = nptk_pkg::PH_SOLO_OCT;
      nptk_pkg::PH_SOLO_OCT:     phase_next = nptk_pkg::PH_SOLO_RESOLVE;
      nptk_pkg::PH_SOLO_RESOLVE: phase_next = nptk_pkg::PH_HANDOFF;
      nptk_pkg::PH_KILL:         phase_next = nptk_pkg::PH_HANDOFF;
      nptk_pkg::PH_NO_ATTACK:    phase_next = nptk_pkg::PH_HANDOFF;
      nptk_pkg::PH_HANDOFF: begin
        snap_valid = 1'b1;
        if (snap_ready) phase_next = nptk_pkg::PH_IDLE;
      end
      default: phase_next = nptk_pkg::PH_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_on         <= 1'b0;
      keys_now        <= '0;
      keys_before     <= '0;
      last_note       <= '0;
      last_note_state <= nptk_pkg::ST_IDLE;
      for (int i = 0; i < NUM_NOTES; i++) begin
        states[i] <= nptk_pkg::ST_IDLE;
      end
    end else begin
      for (int i = 0; i < NUM_NOTES; i++) begin
        states[i] <= states_next[i];
      end
      case (phase)
        nptk_pkg::PH_CHORD: begin
          keys_before <= keys_now;
          keys_now    <= keys_r;
        end
        nptk_pkg::PH_SOLO_KEYS: begin
          keys_before <= keys_now;
          keys_now    <= (keys_r & SOLO_MASK) | (keys_now & ~SOLO_MASK);
          if (cur_valid) last_note <= cur_idx;
          last_note_state <= cs;
        end
        nptk_pkg::PH_KILL: begin
          if (!poly_on) last_note_state <= states[NUM_NOTES-1];
        end
        default: begin
        end
      endcase
      if (mode_flip) begin
        poly_on <= cfg_wdata;
        if (!cfg_wdata) last_note_state <= states[NUM_NOTES-1];
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    case (phase)
      nptk_pkg::PH_IDLE: begin
        keys_r   <= q_keys;
        octave_r <= q_octave;
      end
      nptk_pkg::PH_SOLO_SCAN: begin
        pressed_valid <= |new_vec;
        pressed_idx   <= lowest_set(new_vec);
        held_valid    <= |hold_vec;
        held_idx      <= highest_set(hold_vec);
        released_any  <= |rel_vec;
      end
      nptk_pkg::PH_SOLO_OCT: begin
        // octave change re-triggers the sounding note
        if (octave_r && cur_valid) begin
          pressed_valid <= 1'b1;
          pressed_idx   <= cur_idx;
          held_valid    <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign snap_states = states;

  always_comb begin
    snap_sum.cur_note    = cur_valid ? {1'b0, cur_idx} : '1;
    snap_sum.cur_state   = cs;
    snap_sum.prior_note  = last_note;
    snap_sum.prev_state  = last_note_state;
    snap_sum.any_down    = cur_valid;
    snap_sum.any_pressed = |p_vec;
    snap_sum.legato      = (last_note_state == nptk_pkg::ST_HELD) &&
                           (cs == nptk_pkg::ST_PRESSED);
  end

endmodule

/* rtl/nptk_emit.sv */
// ----------------------------------------------------------------------------
// nptk_emit
// snapshot of a frame, sent one note per cycle to an output register when free
// ----------------------------------------------------------------------------
module nptk_emit #(
  parameter int NUM_NOTES = 33
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                snap_valid,
  output logic                                snap_ready,
  input  nptk_pkg::note_state_t               snap_states [NUM_NOTES],
  input  nptk_pkg::summary_t                  snap_sum,
  output logic                                empty,
  input  logic                                pop,
  output logic [nptk_pkg::NOTE_W-1:0]         note_index,
  output logic [2:0]                          note_state,
  output logic                                last_of_run,
  output logic signed [nptk_pkg::CUR_W-1:0]   current_note,
  output logic [2:0]                          current_state,
  output logic [nptk_pkg::NOTE_W-1:0]         previous_note,
  output logic [2:0]                          previous_state,
  output logic                                any_down,
  output logic                                any_pressed,
  output logic                                legato
);

  localparam logic [nptk_pkg::NOTE_W-1:0] LAST_IDX = nptk_pkg::NOTE_W'(NUM_NOTES - 1);

  nptk_pkg::note_state_t       shadow [NUM_NOTES];
  nptk_pkg::summary_t          sum_r;
  nptk_pkg::summary_t          out_sum;
  nptk_pkg::note_state_t       out_state;
  logic [nptk_pkg::NOTE_W-1:0] k;
  logic                        busy;
  logic                        out_valid;
  logic                        slot_free;
  logic                        send;

  assign slot_free  = !out_valid || pop;
  assign send       = busy && slot_free;
  assign snap_ready = !busy;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (snap_valid && !busy) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (send) begin
        k <= k + 1'b1;
        if (k == LAST_IDX) busy <= 1'b0;
      end
      if (send) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && !busy) begin
      sum_r <= snap_sum;
      for (int i = 0; i < NUM_NOTES; i++) begin
        shadow[i] <= snap_states[i];
      end
    end else if (send) begin
      for (int i = 0; i < NUM_NOTES - 1; i++) begin
        shadow[i] <= shadow[i+1];
      end
      shadow[NUM_NOTES-1] <= nptk_pkg::ST_IDLE;
    end
    if (send) begin
      note_index  <= k;
      out_state   <= shadow[0];
      last_of_run <= (k == LAST_IDX);
      out_sum     <= sum_r;
    end
  end

  assign note_state     = out_state;
  assign current_note   = out_sum.cur_note;
  assign current_state  = out_sum.cur_state;
  assign previous_note  = out_sum.prior_note;
  assign previous_state = out_sum.prev_state;
  assign any_down       = out_sum.any_down;
  assign any_pressed    = out_sum.any_pressed;
  assign legato         = out_sum.legato;

endmodule

/* rtl/note_priority_tracker.sv */
// ----------------------------------------------------------------------------
// note_priority_tracker
// per-note keyboard state tracker with chord and solo voice priority
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  request   push / full          action, keys_down, octave_changed
//  result    empty / pop          note_index, note_state, last_of_run,
//                                 current_note, current_state, previous_note,
//                                 previous_state, any_down, any_pressed, legato
//  config    cfg_we               cfg_wdata (chord mode)
//
//  one request gives NUM_NOTES results, one per note in index order
//  request path: a fetch, 0 to 4 update steps, then a snapshot handoff
//  the result serializer sets the pace when results are popped at once;
//  the next update overlaps that drain
//  rst (synchronous) clears queue, note states, key bitmaps and mode to solo
//  a stalled result holds; two requests can wait in the intake queue
//
module note_priority_tracker #(
  parameter int NUM_NOTES = 33
) (
  input  logic                              clk,
  input  logic                              rst,
  // request side
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action,
  input  logic [NUM_NOTES-1:0]              keys_down,
  input  logic                              octave_changed,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic [nptk_pkg::NOTE_W-1:0]       note_index,
  output logic [2:0]                        note_state,
  output logic                              last_of_run,
  output logic signed [nptk_pkg::CUR_W-1:0] current_note,
  output logic [2:0]                        current_state,
  output logic [nptk_pkg::NOTE_W-1:0]       previous_note,
  output logic [2:0]                        previous_state,
  output logic                              any_down,
  output logic                              any_pressed,
  output logic                              legato
);

  // intake queue to executor
  logic                 q_valid;
  logic                 q_pop;
  nptk_pkg::op_t        q_op;
  logic [NUM_NOTES-1:0] q_keys;
  logic                 q_octave;

  // executor to serializer: full note row plus frame summary
  logic                  snap_valid;
  logic                  snap_ready;
  nptk_pkg::note_state_t snap_states [NUM_NOTES];
  nptk_pkg::summary_t    snap_sum;

  // front: takes requests and decodes the action code
  nptk_front #(
    .NUM_NOTES (NUM_NOTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action         (action),
    .keys_down      (keys_down),
    .octave_changed (octave_changed),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_op           (q_op),
    .q_keys         (q_keys),
    .q_octave       (q_octave)
  );

  // back: holds the note states and walks a request through its steps;
  // a mode change on the config port kills all notes right away
  nptk_exec #(
    .NUM_NOTES (NUM_NOTES)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_op        (q_op),
    .q_keys      (q_keys),
    .q_octave    (q_octave),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_states (snap_states),
    .snap_sum    (snap_sum)
  );

  // serializer: one note per cycle into the result register when it is free
  nptk_emit #(
    .NUM_NOTES (NUM_NOTES)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .snap_valid     (snap_valid),
    .snap_ready     (snap_ready),
    .snap_states    (snap_states),
    .snap_sum       (snap_sum),
    .empty          (empty),
    .pop            (pop),
    .note_index     (note_index),
    .note_state     (note_state),
    .last_of_run    (last_of_run),
    .current_note   (current_note),
    .current_state  (current_state),
    .previous_note  (previous_note),
    .previous_state (previous_state),
    .any_down       (any_down),
    .any_pressed    (any_pressed),
    .legato         (legato)
  );

endmodule

/* rtl/nptk_checker.sv */
// ----------------------------------------------------------------------------
// nptk_checker
// port-level checks on the result stream of the note priority tracker
// ----------------------------------------------------------------------------
`include "note_priority_tracker_assert.svh"

module nptk_checker #(
  parameter int NUM_NOTES = 33
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              empty,
  input logic                              pop,
  input logic [nptk_pkg::NOTE_W-1:0]       note_index,
  input logic [2:0]                        note_state,
  input logic                              last_of_run,
  input logic signed [nptk_pkg::CUR_W-1:0] current_note,
  input logic [2:0]                        current_state,
  input logic                              legato
);

  // notes of one run come out in index order
  `NPT_ASSERT_NOW(a_index_step, (!empty && pop && !last_of_run) ##1 !empty, note_index == $past(note_index) + 1'b1, "note index did not step by one")

  // a run ends on the top note
  `NPT_ASSERT_NOW(a_run_end, !empty && last_of_run, note_index == nptk_pkg::NOTE_W'(NUM_NOTES - 1), "run ended on wrong note")

  // frame summary stays fixed within a run
  `NPT_ASSERT_NOW(a_sum_fixed, (!empty && pop && !last_of_run) ##1 !empty, $stable(current_note) && $stable(current_state) && $stable(legato), "summary changed within run")

  // legato only on a fresh press
  `NPT_ASSERT_NOW(a_legato, !empty && legato, current_state == nptk_pkg::ST_PRESSED, "legato without pressed current note")

  // a waiting result holds
  `NPT_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(note_index) && $stable(note_state), "stalled result changed")

endmodule

bind note_priority_tracker nptk_checker #(.NUM_NOTES(NUM_NOTES)) u_checker (.*);
